@@ rtl/core/sswf_pkg.sv @@
// Shared types and constants for the sync-write framer.
`timescale 1ns / 1ps
`default_nettype none

package sswf_pkg;

  localparam int CNT_W = 6;
  localparam int MT_W = 16;
  localparam int POS_W = 10;

  localparam logic [7:0] SYNC_MARK = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;
  localparam logic [7:0] INSTR_SYNC_WRITE = 8'h83;
  localparam logic [7:0] ADDR_GOAL_POS = 8'h1E;
  localparam logic [7:0] DATA_PER_SERVO = 8'h04;
  localparam logic [9:0] SPEED_FACTOR = 10'd848;
  localparam logic [9:0] SPEED_MAX = 10'd1023;
  localparam logic [9:0] SPEED_MIN = 10'd26;

  localparam logic [MT_W-1:0] MOVE_TIME_RST = 16'd1;
  localparam logic [CNT_W-1:0] SERVO_COUNT_RST = 6'd18;

  typedef enum logic {
    CFG_MOVE_TIME   = 1'b0,
    CFG_SERVO_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]       bus_id;
    logic [POS_W-1:0] current_position;
    logic [POS_W-1:0] goal_position;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } out_t;

  typedef enum logic [3:0] {
    B_SYNC0   = 4'd0,
    B_SYNC1   = 4'd1,
    B_BCAST   = 4'd2,
    B_LEN     = 4'd3,
    B_INSTR   = 4'd4,
    B_ADDR    = 4'd5,
    B_SIZE    = 4'd6,
    B_ID      = 4'd7,
    B_GOAL_LO = 4'd8,
    B_GOAL_HI = 4'd9,
    B_SPD_LO  = 4'd10,
    B_SPD_HI  = 4'd11,
    B_CHK     = 4'd12
  } byte_sel_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    byte_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             div_done;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/servo_sync_write_framer.sv @@
// Top level of the servo-bus sync-write packet framer.
// Each input transaction is one servo record; the block emits its packet bytes one per
// output transaction: a seven-byte header before the first record of a frame, five bytes
// per record (id, goal low/high, speed low/high) and the checksum after the last record,
// flagged by frame_end. The speed quotient comes from a radix-4 restoring divider; header,
// id and goal bytes go out while it runs. Configuration writes are always taken (cfg_ready
// is tied high); index 0 is move_time, index 1 is servo_count.
`timescale 1ns / 1ps
`default_nettype none

module servo_sync_write_framer import sswf_pkg::*; #(
  parameter int MAX_RECORDS = 50
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire in_t             in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_t                 out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [MT_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  sswf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sswf_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/sswf_div.sv @@
// Radix-4 restoring divider for the servo speed quotient.
`timescale 1ns / 1ps
`default_nettype none

module sswf_div import sswf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [19:0]     dividend,
  input  wire logic [MT_W-1:0] divisor,
  output logic                 done,
  output logic [19:0]          quotient
);

  localparam int NumW = 20;
  localparam int DenW = MT_W;
  localparam int StepsPerCycle = 2;
  localparam int Iters = NumW / StepsPerCycle;
  localparam int CntW = $clog2(Iters + 1);

  logic [DenW-1:0] rem_r, rem_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, done_r;

  always_comb begin
    logic [DenW:0] t;
    logic [DenW-1:0] r;
    logic [NumW-1:0] q;
    r = rem_r;
    q = quo_r;
    t = '0;
    for (int i = 0; i < StepsPerCycle; i++) begin
      t = {r, q[NumW-1]};
      q = {q[NumW-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[DenW-1:0];
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CntW'(Iters - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/core/sswf_dp.sv @@
// Datapath: config registers, speed computation, byte selection, checksum, output register.
`timescale 1ns / 1ps
`default_nettype none

module sswf_dp import sswf_pkg::*; #(
  parameter int MAX_RECORDS = 50
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               sts,
  input  wire in_t              in_data,
  output out_t                  out_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_index,
  input  wire logic [MT_W-1:0]  cfg_data
);

  localparam logic [CNT_W-1:0] MaxRec = CNT_W'(MAX_RECORDS);

  logic [MT_W-1:0]  move_time_r;
  logic [CNT_W-1:0] servo_count_r;
  logic [CNT_W-1:0] count_eff;
  logic [7:0]       id_r;
  logic [POS_W-1:0] goal_r;
  logic [7:0]       csum_r, csum_nxt;
  logic             out_valid_r;
  out_t             out_data_r, out_data_nxt;
  logic [POS_W-1:0] travel;
  logic [19:0]      dividend;
  logic [19:0]      quotient;
  logic             div_done;
  logic [9:0]       speed;
  logic [7:0]       len_byte;
  logic [7:0]       cnt8;
  logic             summed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_time_r   <= MOVE_TIME_RST;
      servo_count_r <= SERVO_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MOVE_TIME:   move_time_r <= cfg_data;
        CFG_SERVO_COUNT: servo_count_r <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    count_eff = servo_count_r;
    if (servo_count_r == '0) count_eff = CNT_W'(1);
    if (servo_count_r > MaxRec) count_eff = MaxRec;
  end

  assign travel = (in_data.goal_position >= in_data.current_position) ?
                  in_data.goal_position - in_data.current_position :
                  in_data.current_position - in_data.goal_position;
  assign dividend = 20'(travel) * 20'(SPEED_FACTOR);

  sswf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.accept),
    .dividend (dividend),
    .divisor  (move_time_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    if (quotient > 20'(SPEED_MAX)) speed = SPEED_MAX;
    else if (quotient < 20'(SPEED_MIN)) speed = SPEED_MIN;
    else speed = quotient[9:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_r   <= in_data.bus_id;
      goal_r <= in_data.goal_position;
    end
  end

  assign cnt8 = 8'(count_eff);
  assign len_byte = 8'((cnt8 << 2) + cnt8 + DATA_PER_SERVO);

  always_comb begin
    out_data_nxt.frame_end = 1'b0;
    summed = 1'b1;
    case (cmd.sel)
      B_SYNC0: begin
        out_data_nxt.tx_byte = SYNC_MARK;
        summed = 1'b0;
      end
      B_SYNC1: begin
        out_data_nxt.tx_byte = SYNC_MARK;
        summed = 1'b0;
      end
      B_BCAST:   out_data_nxt.tx_byte = BROADCAST_ID;
      B_LEN:     out_data_nxt.tx_byte = len_byte;
      B_INSTR:   out_data_nxt.tx_byte = INSTR_SYNC_WRITE;
      B_ADDR:    out_data_nxt.tx_byte = ADDR_GOAL_POS;
      B_SIZE:    out_data_nxt.tx_byte = DATA_PER_SERVO;
      B_ID:      out_data_nxt.tx_byte = id_r;
      B_GOAL_LO: out_data_nxt.tx_byte = goal_r[7:0];
      B_GOAL_HI: out_data_nxt.tx_byte = 8'(goal_r[POS_W-1:8]);
      B_SPD_LO:  out_data_nxt.tx_byte = speed[7:0];
      B_SPD_HI:  out_data_nxt.tx_byte = 8'(speed[9:8]);
      B_CHK: begin
        out_data_nxt.tx_byte = ~csum_r;
        out_data_nxt.frame_end = 1'b1;
        summed = 1'b0;
      end
      default: begin
        out_data_nxt.tx_byte = '0;
        summed = 1'b0;
      end
    endcase
  end

  always_comb begin
    csum_nxt = csum_r;
    if (cmd.sel == B_SYNC0 || cmd.sel == B_CHK) csum_nxt = '0;
    else if (summed) csum_nxt = csum_r + out_data_nxt.tx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        csum_r      <= csum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.div_done = div_done;
  assign sts.count = count_eff;

endmodule

`default_nettype wire

@@ rtl/core/sswf_ctrl.sv @@
// Controller: record intake, byte sequencing and frame tracking.
`timescale 1ns / 1ps
`default_nettype none

module sswf_ctrl import sswf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  byte_sel_t        sel_r, sel_nxt;
  logic [CNT_W-1:0] rec_idx_r, rec_idx_nxt;
  logic [CNT_W-1:0] rec_inc;
  logic             accept;
  logic             load;
  logic             spd_byte;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign spd_byte = (sel_r == B_SPD_LO) || (sel_r == B_SPD_HI);
  assign load = (state_r == S_EMIT) && sts.out_free && (!spd_byte || sts.div_done);
  assign rec_inc = rec_idx_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    rec_idx_nxt = rec_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EMIT;
          sel_nxt   = (rec_idx_r == '0) ? B_SYNC0 : B_ID;
        end
      end
      S_EMIT: begin
        if (load) begin
          if (sel_r == B_SPD_HI) begin
            if (rec_inc >= sts.count || rec_inc == '0) begin
              rec_idx_nxt = '0;
              sel_nxt     = B_CHK;
            end else begin
              rec_idx_nxt = rec_inc;
              state_nxt   = S_IDLE;
            end
          end else if (sel_r == B_CHK) begin
            state_nxt = S_IDLE;
          end else begin
            sel_nxt = byte_sel_t'(sel_r + 1'b1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_r     <= B_SYNC0;
      rec_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      sel_r     <= sel_nxt;
      rec_idx_r <= rec_idx_nxt;
    end
  end

  assign cmd.accept = accept;
  assign cmd.load = load;
  assign cmd.sel = sel_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EMIT) && (sel_r == B_SYNC0 || sel_r == B_ID))
    else $error("record transaction did not start a byte sequence");

  a_speed_waits_div: assert property (@(posedge clk) disable iff (!rst_n)
    (load && spd_byte) |-> sts.div_done)
    else $error("speed byte loaded before the quotient was ready");

  a_chk_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (load && sel_r == B_CHK) |=> (state_r == S_IDLE) && (rec_idx_r == '0))
    else $error("checksum byte did not close the frame");

endmodule

`default_nettype wire

@@ dv/servo_sync_write_framer_tb.sv @@
// Self-checking testbench for the servo sync-write packet framer with its own byte predictor.
`timescale 1ns / 1ps

module servo_sync_write_framer_tb;
  import sswf_pkg::*;

  localparam int MAX_REC = 50;
  localparam int RANDOM_RECS = 436;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = CFG_MOVE_TIME;
  logic [MT_W-1:0] cfg_data = '0;

  logic [MT_W-1:0]  move_time_q;
  logic [CNT_W-1:0] servo_count_q;
  logic [CNT_W-1:0] record_idx;
  logic [7:0]       frame_sum;

  out_t expected_bytes[$];
  in_t  servo_recs[$];

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic no_gaps = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  servo_sync_write_framer #(
    .MAX_RECORDS(MAX_REC)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [9:0] speed_for(logic [9:0] cur, logic [9:0] goal,
                                           logic [MT_W-1:0] mt);
    logic [9:0]  travel;
    logic [19:0] quot;
    travel = (goal > cur) ? goal - cur : cur - goal;
    if (mt == '0) return SPEED_MAX;
    quot = (20'(SPEED_FACTOR) * 20'(travel)) / 20'(mt);
    if (quot > 20'(SPEED_MAX)) return SPEED_MAX;
    if (quot < 20'(SPEED_MIN)) return SPEED_MIN;
    return quot[9:0];
  endfunction

  function automatic void push_byte(logic [7:0] b, logic fe, logic summed);
    out_t t;
    t.tx_byte = b;
    t.frame_end = fe;
    expected_bytes.push_back(t);
    if (summed) frame_sum = frame_sum + b;
  endfunction

  function automatic void frame_record(in_t rec);
    logic [CNT_W-1:0] eff;
    logic [9:0]       spd;
    if (servo_count_q == '0) eff = CNT_W'(1);
    else if (servo_count_q > CNT_W'(MAX_REC)) eff = CNT_W'(MAX_REC);
    else eff = servo_count_q;
    spd = speed_for(rec.current_position, rec.goal_position, move_time_q);
    if (record_idx == '0) begin
      frame_sum = '0;
      push_byte(SYNC_MARK, 1'b0, 1'b0);
      push_byte(SYNC_MARK, 1'b0, 1'b0);
      push_byte(BROADCAST_ID, 1'b0, 1'b1);
      push_byte(8'd4 + 8'(eff) * 8'd5, 1'b0, 1'b1);
      push_byte(INSTR_SYNC_WRITE, 1'b0, 1'b1);
      push_byte(ADDR_GOAL_POS, 1'b0, 1'b1);
      push_byte(DATA_PER_SERVO, 1'b0, 1'b1);
    end
    push_byte(rec.bus_id, 1'b0, 1'b1);
    push_byte(rec.goal_position[7:0], 1'b0, 1'b1);
    push_byte({6'd0, rec.goal_position[9:8]}, 1'b0, 1'b1);
    push_byte(spd[7:0], 1'b0, 1'b1);
    push_byte({6'd0, spd[9:8]}, 1'b0, 1'b1);
    record_idx = record_idx + 1'b1;
    if (record_idx >= eff || record_idx == '0) begin
      push_byte(~frame_sum, 1'b1, 1'b0);
      record_idx = '0;
      frame_sum = '0;
    end
  endfunction

  function automatic in_t rand_record();
    in_t r;
    r.bus_id = 8'($urandom);
    r.current_position = 10'($urandom);
    case ($urandom_range(7))
      0: r.goal_position = r.current_position;
      1: r.goal_position = r.current_position + 10'($urandom_range(1, 3));
      2: {r.current_position, r.goal_position} = $urandom_range(1) ?
           {10'd0, 10'd1023} : {10'd1023, 10'd0};
      default: r.goal_position = 10'($urandom);
    endcase
    return r;
  endfunction

  function automatic void queue_rec(logic [7:0] id, logic [9:0] cur, logic [9:0] goal);
    in_t r;
    r = '{id, cur, goal};
    servo_recs.push_back(r);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [MT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (servo_recs.size() != 0 || in_valid);
    do @(negedge clk); while (expected_bytes.size() != 0);
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (servo_recs.size() != 0 && (no_gaps || $urandom_range(99) >= 18)) begin
        in_valid <= 1'b1;
        in_data <= servo_recs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= no_gaps || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin : monitor
    out_t want;
    in_taken <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst_n) begin
      move_time_q = MOVE_TIME_RST;
      servo_count_q = SERVO_COUNT_RST;
      record_idx = '0;
      frame_sum = '0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MOVE_TIME) move_time_q = cfg_data;
        else servo_count_q = cfg_data[CNT_W-1:0];
      end
      if (in_valid && in_ready) frame_record(in_data);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: extra byte: expected none, actual %h end %b",
                   $time, out_data.tx_byte, out_data.frame_end);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.tx_byte !== want.tx_byte) begin
            $display("%0t: tx_byte: expected %h, actual %h",
                     $time, want.tx_byte, out_data.tx_byte);
            mismatches++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $display("%0t: frame_end: expected %b, actual %b",
                     $time, want.frame_end, out_data.frame_end);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int               sent;
    int               batch;
    int               phase;
    logic [MT_W-1:0]  mt;
    logic [CNT_W-1:0] cnt;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    @(posedge clk);
    queue_rec(8'd0, 10'd0, 10'd0);
    queue_rec(8'd253, 10'd0, 10'd1023);
    queue_rec(8'd255, 10'd1023, 10'd0);
    queue_rec(8'd254, 10'd512, 10'd512);
    queue_rec(8'd1, 10'd0, 10'd1);
    queue_rec(8'h80, 10'h155, 10'h2AA);
    queue_rec(8'h7F, 10'h2AA, 10'h155);
    queue_rec(8'hAA, 10'd1023, 10'd1022);
    repeat (10) servo_recs.push_back(rand_record());
    settle();

    write_reg(CFG_MOVE_TIME, '0);
    write_reg(CFG_SERVO_COUNT, 16'd1);
    @(posedge clk);
    repeat (2) servo_recs.push_back(rand_record());
    settle();

    write_reg(CFG_SERVO_COUNT, 16'hFFC0);
    @(posedge clk);
    servo_recs.push_back(rand_record());
    settle();

    write_reg(CFG_MOVE_TIME, 16'hFFFF);
    write_reg(CFG_SERVO_COUNT, 16'd63);
    @(posedge clk);
    repeat (2) servo_recs.push_back(rand_record());
    settle();

    write_reg(CFG_SERVO_COUNT, 16'd2);
    @(posedge clk);
    servo_recs.push_back(rand_record());
    settle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_RECS) begin
      case ($urandom_range(7))
        0: mt = '0;
        1: mt = 16'd1;
        2: mt = 16'hFFFF;
        3, 4: mt = 16'($urandom_range(1, 4000));
        default: mt = 16'($urandom);
      endcase
      case ($urandom_range(7))
        0: cnt = '0;
        1: cnt = 6'd50;
        2: cnt = 6'($urandom_range(51, 63));
        default: cnt = 6'($urandom_range(1, 8));
      endcase
      if ($urandom_range(3) != 0) write_reg(CFG_MOVE_TIME, mt);
      if ($urandom_range(3) != 0) write_reg(CFG_SERVO_COUNT, {10'($urandom), cnt});
      batch = $urandom_range(5, 40);
      @(posedge clk);
      no_gaps = (phase == 3);
      repeat (batch) servo_recs.push_back(rand_record());
      settle();
      sent += batch;
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
